>>> rtl/core/box_blur_5x5_edge_normalized_top_macros.svh
// Assertion macros shared by the box blur RTL.
// Included by modules that carry concurrent checks; depends on nothing.
`ifndef BOX_BLUR_5X5_EDGE_NORMALIZED_TOP_MACROS_SVH
`define BOX_BLUR_5X5_EDGE_NORMALIZED_TOP_MACROS_SVH

// Implication check, disabled while reset is held.
`define BBN_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also active during reset.
`define BBN_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/bbn_pkg.sv
// Package for the 5x5 edge-normalized box blur.
// Holds widths, controller state type and the command/status structs.
package bbn_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned ColW     = 10;
  localparam int unsigned RowW     = 11;
  localparam int unsigned WCfgW    = 11;
  localparam int unsigned HCfgW    = 12;
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 2048;
  localparam int unsigned Span     = 5;
  localparam int unsigned TapW     = 3;
  localparam int unsigned SumW     = 21;
  localparam int unsigned CntW     = 5;
  localparam int unsigned DiffW    = 13;
  localparam int unsigned RowSlotW = 3;
  localparam int unsigned MemAw    = RowSlotW + ColW;
  localparam int unsigned DivStepW = 5;

  // Register indexes on the configuration port.
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_INIT,
    S_DIV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic take;      // input word accepted
    logic rd_en;     // read one window tap
    logic div_init;  // load divider
    logic div_step;  // one divider step
    logic load_out;  // move quotient to output register
  } cmd_t;

  typedef struct packed {
    logic will_emit;
    logic tap_last;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

>>> rtl/core/bbn_in_if.sv
// Input stream channel: valid/ready plus request type and sample.
// Depends on bbn_pkg for the sample width.
interface bbn_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [bbn_pkg::SampleW-1:0] sample_in;

  modport source (output valid, req_type, sample_in, input ready);
  modport sink   (input valid, req_type, sample_in, output ready);
endinterface

>>> rtl/core/bbn_out_if.sv
// Result stream channel: valid/ready plus mean, position and frame end.
// Depends on bbn_pkg for field widths.
interface bbn_out_if;
  logic                        valid;
  logic                        ready;
  logic [bbn_pkg::SampleW-1:0] sample_out;
  logic [bbn_pkg::ColW-1:0]    out_col;
  logic [bbn_pkg::RowW-1:0]    out_row;
  logic                        frame_last;

  modport source (output valid, sample_out, out_col, out_row, frame_last, input ready);
  modport sink   (input valid, sample_out, out_col, out_row, frame_last, output ready);
endinterface

>>> rtl/core/box_blur_5x5_edge_normalized_top.sv
// Top level: 5x5 edge-normalized box blur with APB configuration.
// Samples that emit no result are taken one per cycle. For an item that emits a result,
// the block reads the 25 window taps from the line store, finishes the sum, loads the
// divider, runs the division and loads the output register; the next item is taken
// after that load, later if the previous result is still unread.
// rst_ni (async, low) restores 800x600 and a fresh frame; a register write restarts it.
module box_blur_5x5_edge_normalized_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  bbn_in_if.sink      in_i,
  bbn_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bbn_pkg::cmd_t    cmd;
  bbn_pkg::status_t st;
  logic             cfg_we;

  // APB write strobe; register index is address bit two.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  bbn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  bbn_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (st),
    .req_type_i   (in_i.req_type),
    .sample_i     (in_i.sample_in),
    .cfg_we_i     (cfg_we),
    .cfg_sel_i    (paddr[2]),
    .cfg_wdata_i  (pwdata),
    .cfg_rdata_o  (prdata),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_sample_o (out_o.sample_out),
    .out_col_o    (out_o.out_col),
    .out_row_o    (out_o.out_row),
    .out_last_o   (out_o.frame_last)
  );

endmodule

>>> rtl/core/bbn_ctrl.sv
// Controller for the box blur: sequences tap reads, division and output.
// Depends on bbn_pkg and the assertion macro header.
`include "box_blur_5x5_edge_normalized_top_macros.svh"

module bbn_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bbn_pkg::status_t st_i,
  output bbn_pkg::cmd_t    cmd_o
);

  bbn_pkg::state_e state_q, state_d;
  logic            accept;

  assign accept = in_valid_i && in_ready_o;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbn_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state. The drain state lets the last tap reach the sum before the
  // divider is loaded.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bbn_pkg::S_IDLE: begin
        if (accept && st_i.will_emit) state_d = bbn_pkg::S_READ;
      end
      bbn_pkg::S_READ: begin
        if (st_i.tap_last) state_d = bbn_pkg::S_DRAIN;
      end
      bbn_pkg::S_DRAIN: state_d = bbn_pkg::S_INIT;
      bbn_pkg::S_INIT:  state_d = bbn_pkg::S_DIV;
      bbn_pkg::S_DIV: begin
        if (st_i.div_done) state_d = bbn_pkg::S_OUT;
      end
      bbn_pkg::S_OUT: begin
        if (!st_i.out_busy) state_d = bbn_pkg::S_IDLE;
      end
      default: state_d = bbn_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      bbn_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = accept;
      end
      bbn_pkg::S_READ:  cmd_o.rd_en = 1'b1;
      bbn_pkg::S_INIT:  cmd_o.div_init = 1'b1;
      bbn_pkg::S_DIV:   cmd_o.div_step = !st_i.div_done;
      bbn_pkg::S_OUT:   cmd_o.load_out = !st_i.out_busy;
      default: ;
    endcase
  end

  `BBN_ASSERT(a_div_to_out, clk_i, rst_ni, (state_q == bbn_pkg::S_DIV && st_i.div_done) |=> (state_q == bbn_pkg::S_OUT), "divider finish did not move to output")
  `BBN_ASSERT(a_load_free, clk_i, rst_ni, cmd_o.load_out |-> !st_i.out_busy, "output overwritten")
  `BBN_ASSERT(a_read_end, clk_i, rst_ni, (state_q == bbn_pkg::S_READ && st_i.tap_last) |=> (state_q == bbn_pkg::S_DRAIN), "tap sweep overran")

endmodule

>>> rtl/core/bbn_dp.sv
// Datapath for the box blur: config registers, line store, window sum,
// restoring divider and output register. Depends on bbn_pkg.
module bbn_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bbn_pkg::cmd_t               cmd_i,
  output bbn_pkg::status_t            st_o,
  input  logic                        req_type_i,
  input  logic [bbn_pkg::SampleW-1:0] sample_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_sel_i,
  input  logic [31:0]                 cfg_wdata_i,
  output logic [31:0]                 cfg_rdata_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bbn_pkg::SampleW-1:0] out_sample_o,
  output logic [bbn_pkg::ColW-1:0]    out_col_o,
  output logic [bbn_pkg::RowW-1:0]    out_row_o,
  output logic                        out_last_o
);

  localparam logic [bbn_pkg::TapW-1:0]     TapMax   = 3'(bbn_pkg::Span - 1);
  localparam logic [bbn_pkg::DivStepW-1:0] DivSteps = 5'(bbn_pkg::SumW);

  logic [bbn_pkg::WCfgW-1:0] width_q;
  logic [bbn_pkg::HCfgW-1:0] height_q;
  logic [bbn_pkg::WCfgW-1:0] w;
  logic [bbn_pkg::HCfgW-1:0] h;
  logic [bbn_pkg::DiffW-1:0] lag;

  logic [bbn_pkg::ColW-1:0]  in_col_q, emit_col_q;
  logic [bbn_pkg::RowW-1:0]  in_row_q, emit_row_q;
  logic                      done_q;
  logic [bbn_pkg::DiffW-1:0] diff_q;
  logic                      sample_take, emit_last, restart;

  logic [bbn_pkg::TapW-1:0]  dy_q, dx_q;
  logic signed [12:0]        rr;
  logic signed [11:0]        cc;
  logic                      tap_in;
  logic [bbn_pkg::MemAw-1:0] rd_addr, wr_addr;
  logic [bbn_pkg::SampleW-1:0] mem [2**bbn_pkg::MemAw];
  logic [bbn_pkg::SampleW-1:0] rd_data_q;
  logic                      rd_vld_q, rd_in_q;
  logic [bbn_pkg::SumW-1:0]  sum_q;
  logic [bbn_pkg::CntW-1:0]  n_q;

  logic [bbn_pkg::SumW-1:0]     dvd_q;
  logic [bbn_pkg::CntW:0]       rem_q;
  logic [bbn_pkg::DivStepW-1:0] step_q;
  logic [bbn_pkg::CntW:0]       trial;
  logic                         fits;

  // Effective frame size: zero counts as one, clamp to the maximum.
  always_comb begin
    w = width_q;
    if (width_q == '0) w = 11'd1;
    else if (width_q > 11'(bbn_pkg::MaxWidth)) w = 11'(bbn_pkg::MaxWidth);
    h = height_q;
    if (height_q == '0) h = 12'd1;
    else if (height_q > 12'(bbn_pkg::MaxHeight)) h = 12'(bbn_pkg::MaxHeight);
  end

  assign lag = {1'b0, w, 1'b0} + 13'd2;
  assign cfg_rdata_o = cfg_sel_i ? {20'd0, height_q} : {21'd0, width_q};

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd800;
      height_q <= 12'd600;
    end else if (cfg_we_i) begin
      if (cfg_sel_i == bbn_pkg::RegWidth) width_q <= cfg_wdata_i[bbn_pkg::WCfgW-1:0];
      else height_q <= cfg_wdata_i[bbn_pkg::HCfgW-1:0];
    end
  end

  assign sample_take = cmd_i.take && !done_q && (req_type_i == 1'b0);
  assign emit_last   = ({1'b0, emit_row_q} == h - 12'd1) && ({1'b0, emit_col_q} == w - 11'd1);
  assign restart     = cfg_we_i || (cmd_i.load_out && emit_last);

  assign st_o.will_emit = done_q || ((req_type_i == 1'b0) && (diff_q >= lag));
  assign st_o.tap_last  = (dy_q == TapMax) && (dx_q == TapMax);
  assign st_o.div_done  = (step_q == DivSteps);
  assign st_o.out_busy  = out_valid_o;

  // Frame position counters and the received-minus-emitted distance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0; in_row_q <= '0; emit_col_q <= '0; emit_row_q <= '0;
      done_q <= 1'b0; diff_q <= '0;
    end else if (restart) begin
      in_col_q <= '0; in_row_q <= '0; emit_col_q <= '0; emit_row_q <= '0;
      done_q <= 1'b0; diff_q <= '0;
    end else if (sample_take) begin
      diff_q <= diff_q + 13'd1;
      if ({1'b0, in_col_q} == w - 11'd1) begin
        in_col_q <= '0;
        if ({1'b0, in_row_q} == h - 12'd1) begin
          in_row_q <= '0;
          done_q   <= 1'b1;
        end else begin
          in_row_q <= in_row_q + 11'd1;
        end
      end else begin
        in_col_q <= in_col_q + 10'd1;
      end
    end else if (cmd_i.load_out) begin
      diff_q <= diff_q - 13'd1;
      if ({1'b0, emit_col_q} == w - 11'd1) begin
        emit_col_q <= '0;
        emit_row_q <= emit_row_q + 11'd1;
      end else begin
        emit_col_q <= emit_col_q + 10'd1;
      end
    end
  end

  // Window tap position for the current read.
  assign rr = $signed({2'b00, emit_row_q}) + $signed({10'd0, dy_q}) - 13'sd2;
  assign cc = $signed({2'b00, emit_col_q}) + $signed({9'd0, dx_q}) - 12'sd2;
  assign tap_in = !rr[12] && (rr[11:0] < h) && !cc[11] && (cc[10:0] < w);
  assign rd_addr = {rr[bbn_pkg::RowSlotW-1:0], cc[bbn_pkg::ColW-1:0]};
  assign wr_addr = {in_row_q[bbn_pkg::RowSlotW-1:0], in_col_q};

  // Tap sweep counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dy_q <= '0; dx_q <= '0;
    end else if (cmd_i.take) begin
      dy_q <= '0; dx_q <= '0;
    end else if (cmd_i.rd_en && !st_o.tap_last) begin
      if (dx_q == TapMax) begin
        dx_q <= '0;
        dy_q <= dy_q + 3'd1;
      end else begin
        dx_q <= dx_q + 3'd1;
      end
    end
  end

  // Line store: eight rows, written on samples, read one tap a cycle.
  always_ff @(posedge clk_i) begin
    if (sample_take) mem[wr_addr] <= sample_i;
    rd_data_q <= mem[rd_addr];
  end

  // Read valid pipeline and window accumulation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0; rd_in_q <= 1'b0; sum_q <= '0; n_q <= '0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      rd_in_q  <= tap_in;
      if (cmd_i.take) begin
        sum_q <= '0; n_q <= '0;
      end else if (rd_vld_q && rd_in_q) begin
        sum_q <= sum_q + {5'd0, rd_data_q};
        n_q   <= n_q + 5'd1;
      end
    end
  end

  // Restoring divider, one quotient bit per step.
  assign trial = {rem_q[bbn_pkg::CntW-1:0], dvd_q[bbn_pkg::SumW-1]};
  assign fits  = trial >= {1'b0, n_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q <= '0; rem_q <= '0; step_q <= DivSteps;
    end else if (cmd_i.div_init) begin
      dvd_q  <= sum_q + {17'd0, n_q[bbn_pkg::CntW-1:1]};
      rem_q  <= '0;
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= fits ? trial - {1'b0, n_q} : trial;
      dvd_q  <= {dvd_q[bbn_pkg::SumW-2:0], fits};
      step_q <= step_q + 5'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_sample_o <= dvd_q[bbn_pkg::SampleW-1:0];
      out_col_o    <= emit_col_q;
      out_row_o    <= emit_row_q;
      out_last_o   <= emit_last;
    end
  end

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the 5x5 edge-normalized box blur.
// Depends on bbn_pkg, bbn_in_if, bbn_out_if and box_blur_5x5_edge_normalized_top.
module tb_top;
  import bbn_pkg::*;

  localparam logic ReqPixel = 1'b0;
  localparam logic ReqFlush = 1'b1;
  localparam int unsigned SettleCycles = 120;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned RandomWords = 1450;
  localparam int unsigned HoldCycles = 1500;

  typedef struct packed {
    logic [SampleW-1:0] mean;
    logic [ColW-1:0]    col;
    logic [RowW-1:0]    row;
    logic               last;
  } blur_px_t;

  logic clk_i;
  logic rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bbn_in_if  in_ch ();
  bbn_out_if out_ch ();

  box_blur_5x5_edge_normalized_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: raw registers, stream positions and the current frame.
  logic [WCfgW-1:0] cfg_width;
  logic [HCfgW-1:0] cfg_height;
  int unsigned pos_col, pos_row, blur_col, blur_row;
  bit frame_in_done;
  logic [SampleW-1:0] frame_px [int unsigned];
  blur_px_t blurred_q [$];

  int unsigned err_cnt;
  int unsigned word_cnt;
  int unsigned quiet_cycles;
  bit hold_on;
  event hold_start;
  bit no_gaps;
  bit no_stalls;

  // Clock and reset.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int unsigned eff_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > MaxWidth) return MaxWidth;
    return cfg_width;
  endfunction

  function automatic int unsigned eff_height();
    if (cfg_height == 0) return 1;
    if (cfg_height > MaxHeight) return MaxHeight;
    return cfg_height;
  endfunction

  function automatic void restart_frame();
    pos_col = 0;
    pos_row = 0;
    blur_col = 0;
    blur_row = 0;
    frame_in_done = 0;
    frame_px.delete();
  endfunction

  // Window mean at the next blur position, then advance it.
  function automatic void emit_blur(int unsigned w, int unsigned h);
    int r, c;
    int unsigned sum, n, q;
    blur_px_t px;
    sum = 0;
    n = 0;
    for (int dy = -2; dy <= 2; dy++) begin
      for (int dx = -2; dx <= 2; dx++) begin
        r = int'(blur_row) + dy;
        c = int'(blur_col) + dx;
        if (r >= 0 && r < int'(h) && c >= 0 && c < int'(w)) begin
          sum += frame_px[r * w + c];
          n++;
        end
      end
    end
    q = (sum + n / 2) / n;
    px.mean = q[SampleW-1:0];
    px.col  = blur_col[ColW-1:0];
    px.row  = blur_row[RowW-1:0];
    px.last = (blur_row == h - 1) && (blur_col == w - 1);
    blurred_q = {blurred_q, px};
    blur_col++;
    if (blur_col >= w) begin
      blur_col = 0;
      blur_row++;
    end
    if (px.last || blur_row >= h) restart_frame();
  endfunction

  function automatic void predict_word(logic req, logic [SampleW-1:0] s);
    int unsigned w, h, got;
    w = eff_width();
    h = eff_height();
    if (frame_in_done) begin
      emit_blur(w, h);
      return;
    end
    if (req == ReqFlush) return;
    frame_px[pos_row * w + pos_col] = s;
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) begin
        pos_row = 0;
        frame_in_done = 1;
      end
    end
    got = frame_in_done ? w * h : pos_row * w + pos_col;
    if (got > blur_row * w + blur_col + 2 * w + 2) emit_blur(w, h);
  endfunction

  // Send one word and wait for it to be accepted.
  task automatic send_word(logic req, logic [SampleW-1:0] s);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= req;
    in_ch.sample_in <= s;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_word(req, s);
    word_cnt++;
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Registers change only while the block is idle.
  task automatic wait_idle();
    end_burst();
    while (blurred_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegWidth) cfg_width = value[WCfgW-1:0];
    else cfg_height = value[HCfgW-1:0];
    restart_frame();
  endtask

  task automatic set_frame(logic [31:0] w, logic [31:0] h);
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
  endtask

  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Stream one full frame and drain it; flush noise goes in before the end.
  task automatic run_frame(int unsigned noise_pct);
    int unsigned total;
    total = eff_width() * eff_height();
    for (int unsigned i = 0; i < total; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_word(ReqFlush, pick_sample());
      send_word(ReqPixel, pick_sample());
    end
    while (frame_in_done)
      send_word($urandom_range(0, 1) ? ReqFlush : ReqPixel, pick_sample());
  endtask

  // Start a frame and abandon it partway.
  task automatic run_partial(int unsigned words);
    for (int unsigned i = 0; i < words; i++) send_word(ReqPixel, pick_sample());
  endtask

  task automatic test_reset_defaults();
    // Default 800x600 frame: a few samples, no result yet, then abandoned.
    send_word(ReqFlush, 16'hFFFF);
    run_partial(6);
    wait_idle();
  endtask

  task automatic test_edge_frames();
    // Tiny frame with corner values, early flush ignored.
    set_frame(5, 5);
    send_word(ReqFlush, 16'h0000);
    for (int i = 0; i < 25; i++) send_word(ReqPixel, (i % 2) ? 16'hFFFF : 16'h0000);
    while (frame_in_done) send_word(ReqPixel, 16'h1234);
    wait_idle();
    // Zero width and height act as a single pixel.
    set_frame(0, 0);
    run_frame(0);
    wait_idle();
    set_frame(1, 1);
    run_frame(0);
    wait_idle();
    // Over-range registers clamp to the maximum; abandoned early.
    set_frame(2047, 4095);
    run_partial(12);
    wait_idle();
    set_frame(1024, 2048);
    run_partial(8);
    wait_idle();
  endtask

  task automatic test_random_frames();
    int unsigned start;
    bit held;
    bit hold_now;
    start = word_cnt;
    held = 0;
    while (word_cnt - start < RandomWords) begin
      no_gaps   = ($urandom_range(0, 4) == 0);
      no_stalls = ($urandom_range(0, 4) == 0);
      hold_now  = 0;
      // The first frame always gets a small size so the maximum frame is left behind.
      if (word_cnt == start || $urandom_range(0, 3) != 0)
        set_frame($urandom_range(1, 12), $urandom_range(1, 10));
      if (!held && word_cnt - start > RandomWords / 2 && eff_width() * eff_height() > 20) begin
        // Long receiver hold-off over a full frame so the block backs up its input.
        -> hold_start;
        no_gaps = 1;
        held = 1;
        hold_now = 1;
      end
      if (!hold_now && $urandom_range(0, 7) == 0)
        run_partial($urandom_range(1, eff_width() * eff_height()));
      else run_frame(10);
      wait_idle();
    end
    no_gaps = 0;
    no_stalls = 0;
  endtask

  // Receiver hold-off, counted in its own process once a test starts it.
  always begin
    @(hold_start);
    hold_on = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_on = 1'b0;
  end

  // Result checker and receiver stalls.
  int unsigned stall_left;
  always @(posedge clk_i) begin
    blur_px_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (blurred_q.size() == 0) begin
        $error("unexpected result: mean %0d col %0d row %0d", out_ch.sample_out,
               out_ch.out_col, out_ch.out_row);
        err_cnt++;
      end else begin
        want = blurred_q.pop_front();
        if (out_ch.sample_out !== want.mean) begin
          $error("sample_out expected %0d got %0d", want.mean, out_ch.sample_out);
          err_cnt++;
        end
        if (out_ch.out_col !== want.col) begin
          $error("out_col expected %0d got %0d", want.col, out_ch.out_col);
          err_cnt++;
        end
        if (out_ch.out_row !== want.row) begin
          $error("out_row expected %0d got %0d", want.row, out_ch.out_row);
          err_cnt++;
        end
        if (out_ch.frame_last !== want.last) begin
          $error("frame_last expected %0d got %0d", want.last, out_ch.frame_last);
          err_cnt++;
        end
      end
      stall_left = no_stalls ? 0 : $urandom_range(0, 17);
    end
    if (hold_on) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0 && !(out_ch.valid && out_ch.ready)) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (stall_left == 0);
    end
  end

  // Watchdog on cycles with no accepted word of any kind.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.req_type  <= ReqPixel;
    in_ch.sample_in <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    cfg_width  = 800;
    cfg_height = 600;
    restart_frame();
    word_cnt = 0;
    no_gaps = 0;
    no_stalls = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    test_reset_defaults();
    test_edge_frames();
    test_random_frames();
    wait_idle();
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
